>>> design/plcl_pkg.sv
// Shared widths, codes and handshake structs for the curve lookup block.
// No dependencies; every other design file depends on this package.
`default_nettype none

package plcl_pkg;

  // Field widths
  localparam int DAY_W       = 16;
  localparam int RATE_W      = 32;
  localparam int IDX_W       = 5;
  localparam int COUNT_W     = 6;
  localparam int ENTRY_W     = DAY_W + RATE_W;
  localparam int PROD_W      = RATE_W + DAY_W;

  // Default table depth
  localparam int MAX_PILLARS_DEF = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PILLAR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SHIFT   = 2'd1;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [DAY_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/plcl_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on plcl_pkg for field widths.
`default_nettype none

interface plcl_item_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [plcl_pkg::IDX_W-1:0]   pillar_index;
  logic [plcl_pkg::DAY_W-1:0]   day;
  logic signed [plcl_pkg::RATE_W-1:0] rate;

  modport source (output valid, op, pillar_index, day, rate, input ready);
  modport sink   (input valid, op, pillar_index, day, rate, output ready);
endinterface

interface plcl_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [plcl_pkg::RATE_W-1:0] curve_rate;

  modport source (output valid, curve_rate, input ready);
  modport sink   (input valid, curve_rate, output ready);
endinterface

interface plcl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [plcl_pkg::CFG_IDX_W-1:0]    index;
  logic [plcl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/piecewise_linear_curve_lookup.sv
// Piecewise-linear curve lookup. A load item (op 0) writes one pillar, a day
// and a signed Q4.28 rate, into the pillar table and gives no result; slots
// at or beyond MAX_PILLARS are dropped. A query item (op 1) returns one
// curve_rate: the first rate on or before the first pillar, the last rate on
// or after the last pillar in use, and otherwise the linear interpolation
// between the bracketing pair, truncated toward zero, plus rate_shift,
// wrapping in 32 bits. Pillars must be loaded with strictly increasing days,
// and a query must touch only slots that were loaded. The table is one
// synchronous RAM read one entry per cycle. A flat query on the first pillar
// passes S_FIRST and S_FINISH before its result is registered, one on the
// last pillar S_FIRST, S_LAST and S_FINISH; an interior query runs a linear
// scan of the table for the bracketing pair, then S_PREP, S_MUL, a 32-step
// bit-serial divide by the pillar interval that reports done when its steps
// end, and S_FINISH. The next item can transfer in the same cycle that the
// result appears at the output. One item is in flight at a time; the
// finished result sits in an output register so the next item transfers
// while it waits, and a query that finishes while that register is still
// full holds until it is read. Configuration writes land in their registers
// and must only come when the block is idle. Depends on plcl_pkg, plcl_if,
// plcl_ram, plcl_div.
`default_nettype none

module piecewise_linear_curve_lookup #(
  parameter int MAX_PILLARS = plcl_pkg::MAX_PILLARS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  plcl_cfg_if.sink      cfg_i,
  plcl_item_if.sink     item_i,
  plcl_result_if.source result_o
);
  import plcl_pkg::*;

  localparam int AW = $clog2(MAX_PILLARS);
  localparam int CW = $clog2(MAX_PILLARS + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_e;

  // Control state
  state_e                    state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [RATE_W-1:0]  out_data_q, out_data_d;
  logic [COUNT_W-1:0]        pillar_count_q, pillar_count_d;
  logic signed [RATE_W-1:0]  rate_shift_q, rate_shift_d;

  // Query datapath
  logic [DAY_W-1:0]          qday_q, qday_d;
  logic [CW-1:0]             n_q, n_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic [DAY_W-1:0]          lo_day_q, lo_day_d;
  logic signed [RATE_W-1:0]  lo_rate_q, lo_rate_d;
  logic [DAY_W-1:0]          hi_day_q, hi_day_d;
  logic signed [RATE_W-1:0]  hi_rate_q, hi_rate_d;
  logic [RATE_W-1:0]         mag_q, mag_d;
  logic [DAY_W-1:0]          off_q, off_d;
  logic [DAY_W-1:0]          span_q, span_d;
  logic                      neg_q, neg_d;
  logic signed [RATE_W-1:0]  res_q, res_d;

  // Memory ports
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [ENTRY_W-1:0]        mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [ENTRY_W-1:0]        mem_rdata;
  logic [DAY_W-1:0]          rd_day;
  logic signed [RATE_W-1:0]  rd_rate;

  // Helpers
  logic                      item_xfer;
  logic                      cfg_xfer;
  logic                      out_load;
  logic [MW-1:0]             cnt_ext;
  logic [CW-1:0]             n_active;
  logic signed [RATE_W:0]    diff;
  logic [PROD_W-1:0]         prod;
  logic [RATE_W-1:0]         quot_signed;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign item_i.ready    = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign result_o.valid  = out_valid_q;
  assign result_o.curve_rate = out_data_q;

  assign item_xfer = item_i.valid && item_i.ready;
  assign cfg_xfer  = cfg_i.valid && cfg_i.ready;

  assign rd_day  = mem_rdata[ENTRY_W-1:RATE_W];
  assign rd_rate = mem_rdata[RATE_W-1:0];

  // Loads write straight through on transfer; slots past the table drop.
  assign mem_we    = item_xfer && (item_i.op == OP_LOAD)
                     && (32'(item_i.pillar_index) < MAX_PILLARS);
  assign mem_waddr = AW'(item_i.pillar_index);
  assign mem_wdata = {item_i.day, item_i.rate};

  // Pillars in use: zero counts as one, saturate at the table depth.
  always_comb begin
    cnt_ext = MW'(pillar_count_q);
    if (cnt_ext == '0) begin
      n_active = CW'(1);
    end else if (cnt_ext > MW'(MAX_PILLARS)) begin
      n_active = CW'(MAX_PILLARS);
    end else begin
      n_active = CW'(cnt_ext);
    end
  end

  assign diff = {hi_rate_q[RATE_W-1], hi_rate_q} - {lo_rate_q[RATE_W-1], lo_rate_q};
  assign prod = mag_q * off_q;
  assign quot_signed = neg_q ? (RATE_W'(0) - div_rsp.quot) : div_rsp.quot;

  plcl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PILLARS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  plcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d        = state_q;
    pillar_count_d = pillar_count_q;
    rate_shift_d   = rate_shift_q;
    qday_d         = qday_q;
    n_d            = n_q;
    idx_d          = idx_q;
    lo_day_d       = lo_day_q;
    lo_rate_d      = lo_rate_q;
    hi_day_d       = hi_day_q;
    hi_rate_d      = hi_rate_q;
    mag_d          = mag_q;
    off_d          = off_q;
    span_d         = span_q;
    neg_d          = neg_q;
    res_d          = res_q;
    mem_raddr      = '0;
    out_load       = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = prod;
    div_req.den    = span_q;

    // Register writes; indexes past the list are ignored.
    if (cfg_xfer) begin
      case (cfg_i.index)
        CFG_PILLAR_COUNT: pillar_count_d = cfg_i.data[COUNT_W-1:0];
        CFG_RATE_SHIFT:   rate_shift_d   = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        // Query: capture the day and pillar count, fetch the first pillar.
        if (item_xfer && (item_i.op == OP_QUERY)) begin
          qday_d    = item_i.day;
          n_d       = n_active;
          mem_raddr = '0;
          state_d   = S_FIRST;
        end
      end
      S_FIRST: begin
        // First pillar is on the bus: flat left edge or single pillar ends here.
        lo_day_d  = rd_day;
        lo_rate_d = rd_rate;
        if ((n_q == CW'(1)) || (qday_q <= rd_day)) begin
          res_d   = rd_rate;
          state_d = S_FINISH;
        end else begin
          mem_raddr = AW'(n_q - CW'(1));
          state_d   = S_LAST;
        end
      end
      S_LAST: begin
        // Last pillar in use: flat right edge, else start the bracket scan.
        if (qday_q >= rd_day) begin
          res_d   = rd_rate;
          state_d = S_FINISH;
        end else begin
          idx_d     = AW'(1);
          mem_raddr = AW'(1);
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // Advance the lower pillar while the next one is not past the query.
        if (rd_day <= qday_q) begin
          lo_day_d  = rd_day;
          lo_rate_d = rd_rate;
          idx_d     = idx_q + AW'(1);
          mem_raddr = idx_q + AW'(1);
        end else begin
          hi_day_d  = rd_day;
          hi_rate_d = rd_rate;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        // Split the rate step into sign and magnitude; offset and interval.
        neg_d   = diff[RATE_W];
        mag_d   = diff[RATE_W] ? RATE_W'(-diff) : RATE_W'(diff);
        off_d   = qday_q - lo_day_q;
        span_d  = hi_day_q - lo_day_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        // The divider captures offset * |step| straight off the multiplier.
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = lo_rate_q + $signed(quot_signed);
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_data_d = out_load ? (res_q + rate_shift_q) : out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      pillar_count_q <= COUNT_W'(1);
      rate_shift_q   <= '0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      out_data_q     <= out_data_d;
      pillar_count_q <= pillar_count_d;
      rate_shift_q   <= rate_shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qday_q    <= qday_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    lo_day_q  <= lo_day_d;
    lo_rate_q <= lo_rate_d;
    hi_day_q  <= hi_day_d;
    hi_rate_q <= hi_rate_d;
    mag_q     <= mag_d;
    off_q     <= off_d;
    span_q    <= span_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (CW'(idx_q) < n_q) && (idx_q != '0))
    else $error("bracket scan ran past the pillars in use");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) && out_valid_q && !result_o.ready
    |=> (state_q == S_FINISH) && out_valid_q && $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> design/plcl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on plcl_pkg for parameter defaults.
`default_nettype none

module plcl_ram #(
  parameter int WIDTH = plcl_pkg::ENTRY_W,
  parameter int DEPTH = plcl_pkg::MAX_PILLARS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/plcl_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Needs num / den < 2**RATE_W. Depends on plcl_pkg for widths and structs.
`default_nettype none

module plcl_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire plcl_pkg::div_req_t  req_i,
  output plcl_pkg::div_rsp_t       rsp_o
);
  import plcl_pkg::*;

  logic [DAY_W-1:0]     rem_q, rem_d;
  logic [RATE_W-1:0]    low_q, low_d;
  logic [DAY_W-1:0]     den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DAY_W:0] trial;
  logic [DAY_W:0] trial_sub;
  logic           take;

  always_comb begin
    trial     = {rem_q, low_q[RATE_W-1]};
    trial_sub = trial - {1'b0, den_q};
    take      = (trial >= {1'b0, den_q});

    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      rem_d  = req_i.num[PROD_W-1:RATE_W];
      low_d  = req_i.num[RATE_W-1:0];
      den_d  = req_i.den;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? trial_sub[DAY_W-1:0] : trial[DAY_W-1:0];
      low_d = {low_q[RATE_W-2:0], take};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_busy_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

`default_nettype wire
